>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, result codes and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned SEXT_W  = 6;

	// Depth of the result queue; it must hold at least two results.
	localparam int unsigned RES_DEPTH = 4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_BYTE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OK       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BADCHAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BADLEN   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONCANON = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [KIND_W-1:0] kind;
		logic              last_of_run;
	} result_t;

	typedef struct packed {
		logic              ok;
		logic [SEXT_W-1:0] val;
	} sextet_t;

	// Maps a character of the standard alphabet to its six-bit value.
	function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
		sextet_t r;
		r.ok  = 1'b1;
		r.val = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.val = SEXT_W'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.val = SEXT_W'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.val = SEXT_W'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if / b64d_out_if
// Valid/ready channels for characters into and results out of the decoder.
// ----------------------------------------------------------------------------
interface b64d_in_if;
	logic                          valid;
	logic                          ready;
	logic [b64d_pkg::CHAR_W-1:0]   in_char;
	logic                          is_last;

	modport source (output valid, output in_char, output is_last, input ready);
	modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface b64d_out_if;
	logic                          valid;
	logic                          ready;
	logic [b64d_pkg::BYTE_W-1:0]   out_byte;
	logic [b64d_pkg::KIND_W-1:0]   kind;
	logic                          last_of_run;

	modport source (output valid, output out_byte, output kind, output last_of_run,
		input ready);
	modport sink   (input valid, input out_byte, input kind, input last_of_run,
		output ready);
endinterface

>>> hw/rtl/base64_unpadded_strict_decoder.sv
// ----------------------------------------------------------------------------
// base64_unpadded_strict_decoder
// Strict unpadded base64 decoder: one character per beat in, bytes and an
// end-of-string status out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                          Beat
//   in_ch    sink       in_char[7:0], is_last            one character
//   res_ch   source     out_byte[7:0], kind[2:0],        one result
//                       last_of_run
//
// A character is taken into an input register, decoded in the next cycle and
// its zero, one or two results are written into a four-entry result queue.
// The input side accepts one beat per cycle as long as the queue has room for
// two results, so a character beat never waits on a result that is still
// unread unless the queue is near full. Reset clears the decode state, the
// input register and the queue; the block is ready in the first cycle after
// reset is released. Results leave at one per cycle while the receiver holds
// ready high, and a string of N characters yields at most N results (about
// three bytes for every four characters plus its status beat), so the output
// keeps up with the input.
// ----------------------------------------------------------------------------
module base64_unpadded_strict_decoder #(
	parameter int unsigned RES_DEPTH = b64d_pkg::RES_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	b64d_in_if.sink         in_ch,
	b64d_out_if.source      res_ch
);

	localparam int unsigned PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

	// ------------------------------------------------------------------
	// Input register.
	// ------------------------------------------------------------------
	logic                         valid_s1;
	logic [b64d_pkg::CHAR_W-1:0]  char_s1;
	logic                         last_s1;

	// Decode state. The pending bit count is always even, so it is held
	// in units of two bits (0, 1, 2 or 3 meaning 0, 2, 4 or 6 bits).
	logic [b64d_pkg::SEXT_W-1:0]  residue_q;
	logic [1:0]                   pend_half_q;
	logic [1:0]                   phase_q;
	logic                         bad_q;

	// Result queue.
	b64d_pkg::result_t            res_mem [RES_DEPTH];
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [CNT_W-1:0]             count_q;

	logic in_fire;
	logic adv;
	logic pop;

	// The decoded item moves into the queue only when two slots are free,
	// which covers the worst case of a byte plus a status.
	assign adv        = valid_s1 && (count_q <= CNT_W'(RES_DEPTH - 2));
	assign in_ch.ready = !valid_s1 || adv;
	assign in_fire    = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= in_ch.in_char;
			last_s1 <= in_ch.is_last;
		end
	end

	// ------------------------------------------------------------------
	// Decode of the registered character.
	// ------------------------------------------------------------------
	b64d_pkg::sextet_t           sx;
	logic                        bad_now;
	logic [11:0]                 acc;
	logic                        byte_en;
	logic [b64d_pkg::BYTE_W-1:0] byte_val;
	logic [b64d_pkg::SEXT_W-1:0] residue_nx;
	logic [1:0]                  pend_half_nx;
	logic [1:0]                  phase_nx;
	logic [b64d_pkg::KIND_W-1:0] status_kind;
	b64d_pkg::result_t           res0;
	b64d_pkg::result_t           res1;
	logic [1:0]                  push_n;

	always_comb begin
		sx           = b64d_pkg::sextet_of(char_s1);
		bad_now      = bad_q || !sx.ok;
		acc          = {residue_q, sx.val};
		byte_en      = 1'b0;
		byte_val     = '0;
		residue_nx   = residue_q;
		pend_half_nx = pend_half_q;
		if (!bad_now) begin
			// Six new bits on top of 0, 2, 4 or 6 pending bits.
			case (pend_half_q)
				2'd0: begin
					residue_nx   = sx.val;
					pend_half_nx = 2'd3;
				end
				2'd3: begin
					byte_en      = 1'b1;
					byte_val     = acc[11:4];
					residue_nx   = {2'b00, acc[3:0]};
					pend_half_nx = 2'd2;
				end
				2'd2: begin
					byte_en      = 1'b1;
					byte_val     = acc[9:2];
					residue_nx   = {4'b0000, acc[1:0]};
					pend_half_nx = 2'd1;
				end
				default: begin
					byte_en      = 1'b1;
					byte_val     = acc[7:0];
					residue_nx   = '0;
					pend_half_nx = 2'd0;
				end
			endcase
		end
		phase_nx = phase_q + 2'd1;

		// Length remainder of one outranks a bad character, which outranks
		// non-zero leftover bits.
		if (phase_nx == 2'd1) begin
			status_kind = b64d_pkg::KIND_BADLEN;
		end else if (bad_now) begin
			status_kind = b64d_pkg::KIND_BADCHAR;
		end else if (pend_half_nx != 2'd0 && residue_nx != '0) begin
			status_kind = b64d_pkg::KIND_NONCANON;
		end else begin
			status_kind = b64d_pkg::KIND_OK;
		end

		res0 = '{out_byte: byte_val, kind: b64d_pkg::KIND_BYTE,
			last_of_run: !last_s1};
		res1 = '{out_byte: '0, kind: status_kind, last_of_run: 1'b1};
		if (!byte_en) begin
			res0 = res1;
		end
		push_n = adv ? ({1'b0, byte_en} + {1'b0, last_s1}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_q   <= '0;
			pend_half_q <= '0;
			phase_q     <= '0;
			bad_q       <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				// End of string: back to the reset state for the next one.
				residue_q   <= '0;
				pend_half_q <= '0;
				phase_q     <= '0;
				bad_q       <= 1'b0;
			end else begin
				residue_q   <= residue_nx;
				pend_half_q <= pend_half_nx;
				phase_q     <= phase_nx;
				bad_q       <= bad_now;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue.
	// ------------------------------------------------------------------
	logic [PTR_W-1:0] wr_ptr_p1;

	assign wr_ptr_p1 = (wr_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			res_mem[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			res_mem[wr_ptr_p1] <= res1;
		end
	end

	assign res_ch.valid       = (count_q != '0);
	assign res_ch.out_byte    = res_mem[rd_ptr_q].out_byte;
	assign res_ch.kind        = res_mem[rd_ptr_q].kind;
	assign res_ch.last_of_run = res_mem[rd_ptr_q].last_of_run;
	assign pop                = res_ch.valid && res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= (wr_ptr_p1 == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_p1 + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// The queue never holds more results than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	// A character held back by a full queue keeps its place in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled character lost");

	// After the last character of a string the decode state is back at reset.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == 2'd0 && pend_half_q == 2'd0 && !bad_q)
		else $error("decode state not cleared at end of string");

	// Status results always carry a zero byte and close their run.
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.kind != b64d_pkg::KIND_BYTE |->
			res_ch.out_byte == '0 && res_ch.last_of_run)
		else $error("malformed status result");

endmodule

>>> dv/tb_base64_unpadded_strict_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_unpadded_strict_decoder
// Self-checking bench for the strict unpadded base64 decoder. Characters are
// sent over the input channel, and a decode model inside the bench predicts the
// byte and status beats. Every result beat is compared against the oldest
// prediction. Both channels idle at random, and the bench also covers long
// output stalls and full drains between strings.
// ----------------------------------------------------------------------------
module tb_base64_unpadded_strict_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	// The limit lies far above the length of the slowest legal run, so it only
	// catches a hang.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned MAX_IDLE    = 16;
	localparam int unsigned LONG_HOLD   = 300;
	localparam string       B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic clk;
	logic arst_n;

	b64d_in_if  in_ch ();
	b64d_out_if res_ch ();

	base64_unpadded_strict_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.res_ch (res_ch)
	);

	// Character-to-sextet lookup. It is filled from the alphabet string at
	// the start of the run. Characters outside the alphabet map to -1.
	int sextet_tab [256];

	// Decode state of the model. It mirrors what the block keeps per string.
	logic [5:0] acc_bits       = '0;
	logic [2:0] acc_count      = '0;
	logic [1:0] chars_mod4     = '0;
	logic       string_tainted = 1'b0;

	// Predicted result beats, oldest first.
	b64d_pkg::result_t predicted_results [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Idling switches for each side, and a request for one long output stall.
	bit          src_idle_on = 1'b0;
	bit          snk_idle_on = 1'b0;
	int unsigned hold_len    = 0;

	// 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hang guard. It counts cycles and ends the run once the limit is reached.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic note_mismatch(string what, int expected_val, int actual_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] %s: expected %0d, got %0d", $time, what, expected_val,
				actual_val);
	endtask

	// Model of one accepted character. A valid character adds six bits to the
	// residue, and a byte leaves as soon as eight bits are present. After the
	// first character outside the alphabet, the string only counts length.
	// The last character adds a status beat and clears the state.
	function automatic void predict_decode(logic [7:0] c, logic last);
		logic [11:0]       joined;
		int                sx;
		int unsigned       bits;
		b64d_pkg::result_t r;
		sx = sextet_tab[c];
		if (sx < 0)
			string_tainted = 1'b1;
		if (!string_tainted) begin
			bits   = acc_count + 6;
			joined = {acc_bits, 6'(sx)};
			if (bits >= 8) begin
				bits          -= 8;
				r.out_byte    = 8'(joined >> bits);
				r.kind        = b64d_pkg::KIND_BYTE;
				// A byte closes the beat group only when no status follows.
				r.last_of_run = !last;
				predicted_results.insert(predicted_results.size(), r);
				acc_bits = 6'(joined & ((12'd1 << bits) - 12'd1));
			end else begin
				acc_bits = 6'(sx);
			end
			acc_count = 3'(bits);
		end
		chars_mod4 = chars_mod4 + 2'd1;
		if (last) begin
			r.out_byte    = '0;
			r.last_of_run = 1'b1;
			// Precedence: a length of 1 mod 4 first, then a bad character,
			// then leftover bits that are not zero.
			if (chars_mod4 == 2'd1)
				r.kind = b64d_pkg::KIND_BADLEN;
			else if (string_tainted)
				r.kind = b64d_pkg::KIND_BADCHAR;
			else if (acc_count != 0 && acc_bits != 0)
				r.kind = b64d_pkg::KIND_NONCANON;
			else
				r.kind = b64d_pkg::KIND_OK;
			predicted_results.insert(predicted_results.size(), r);
			acc_bits       = '0;
			acc_count      = '0;
			chars_mod4     = '0;
			string_tainted = 1'b0;
		end
	endfunction

	// Sends one character beat. A new beat either follows the previous one
	// directly, so valid stays high, or comes after a random gap with valid
	// low. Inputs change on the falling edge. The handshake is sampled on the
	// rising edge.
	task automatic send_char(logic [7:0] c, logic last);
		int unsigned gap;
		gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_char <= c;
		in_ch.is_last <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_decode(c, last);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Sends one string. Most strings are well formed, and a tail character
	// usually has zero leftover bits so that most strings end ok. A noisy
	// string gets one random byte at a random position, and that byte is often
	// outside the alphabet.
	task automatic send_random_string(int unsigned len, bit noisy);
		int          bad_pos;
		int unsigned sx;
		logic [7:0]  c;
		bad_pos = noisy ? int'($urandom_range(0, len - 1)) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == bad_pos) begin
				c = 8'($urandom_range(0, 255));
			end else if (i == len - 1 && len % 4 inside {2, 3} &&
					$urandom_range(0, 9) < 7) begin
				sx = (len % 4 == 2) ? $urandom_range(0, 3) * 16 : $urandom_range(0, 15) * 4;
				c  = B64_ALPHABET[sx];
			end else begin
				c = B64_ALPHABET[$urandom_range(0, 63)];
			end
			send_char(c, i == len - 1);
		end
	endtask

	// Sends random strings until about n_chars characters are used. Lengths
	// of 1 mod 4 are made rarer, because they always end with a bad length.
	task automatic send_string_batch(int unsigned n_chars);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_chars) begin
			len = $urandom_range(1, 16);
			if (len % 4 == 1 && $urandom_range(0, 2) != 0)
				len++;
			send_random_string(len, $urandom_range(0, 6) == 0);
			sent += len;
		end
	endtask

	// Lowers valid on the first falling edge after the last beat. Then it
	// waits until every predicted result beat has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// Covers the field extremes and each way a string can end. It uses
	// canonical tails of two and three characters, a tail with non-zero
	// leftover bits and a one-character string. It also uses bytes 0x00 and
	// 0xFF as bad characters, a bad character that ends the string, the all-ones
	// byte, and the boundaries Z, z, 0, 9 and + inside a string of bad length.
	task automatic test_directed_strings();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		send_text("TWFu");
		send_text("TWE");
		send_text("TQ");
		send_text("TR");
		send_text("T");
		send_text("//8");
		send_char(8'h00, 1'b0);
		send_char("A", 1'b1);
		send_char("A", 1'b0);
		send_char(8'hFF, 1'b1);
		send_text("Zz09+");
		wait_drained();
	endtask

	// Random strings with every combination of input and output idling,
	// including stretches where neither side idles.
	task automatic test_random_traffic();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		send_string_batch(300);
		src_idle_on = 1'b1;
		send_string_batch(250);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		send_string_batch(250);
		src_idle_on = 1'b1;
		send_string_batch(250);
		wait_drained();
	endtask

	// The receiver stops for a long stretch while characters keep coming
	// back to back. The result queue fills, and the input must stall without
	// losing or repeating a beat.
	task automatic test_output_stall();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		hold_len    = LONG_HOLD;
		send_string_batch(60);
		wait_drained();
	endtask

	// The sender pauses after each string until every result is out. Each
	// string then starts on an empty pipeline.
	task automatic test_drain_between_strings();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		repeat (8) begin
			send_random_string($urandom_range(2, 8), $urandom_range(0, 3) == 0);
			wait_drained();
		end
	endtask

	// Output side. When sink idling is on, the receiver holds ready low for a
	// random gap before each result beat. A long hold request takes the place of
	// that wait, and the receiver counts it down here.
	initial begin : result_ready_driver
		int unsigned stall_left;
		stall_left   = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				stall_left = hold_len;
				hold_len   = 0;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				stall_left = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
	end

	// Result checker. Each beat taken from the block is matched against the
	// oldest prediction, field by field.
	initial begin : result_checker
		b64d_pkg::result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (predicted_results.size() == 0) begin
					note_mismatch("result beat with none predicted, kind", -1,
						int'(res_ch.kind));
				end else begin
					exp_r = predicted_results.pop_front();
					if (res_ch.out_byte !== exp_r.out_byte)
						note_mismatch("out_byte", int'(exp_r.out_byte),
							int'(res_ch.out_byte));
					if (res_ch.kind !== exp_r.kind)
						note_mismatch("kind", int'(exp_r.kind), int'(res_ch.kind));
					if (res_ch.last_of_run !== exp_r.last_of_run)
						note_mismatch("last_of_run", int'(exp_r.last_of_run),
							int'(res_ch.last_of_run));
				end
			end
		end
	end

	// Main sequence: build the lookup, run reset once, and run the tests in
	// turn. Then wait for any stray beat and report.
	initial begin
		foreach (sextet_tab[i])
			sextet_tab[i] = -1;
		for (int i = 0; i < 64; i++)
			sextet_tab[B64_ALPHABET[i]] = i;

		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_char = '0;
		in_ch.is_last = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_strings();
		test_random_traffic();
		test_output_stall();
		test_drain_between_strings();

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_if.sv
hw/rtl/base64_unpadded_strict_decoder.sv
dv/tb_base64_unpadded_strict_decoder.sv
